### src/pst_pkg.sv
// ----------------------------------------------------------------------------
// pst_pkg
// shared types and constants of the pausable skip/stop timer
// ----------------------------------------------------------------------------
package pst_pkg;

  // default width of internal time values
  localparam int TIME_WIDTH_DEF = 32;

  // field widths of the word on both channels
  localparam int REQ_W  = 3;
  localparam int FLD_W  = 32;
  localparam int SKIP_W = 16;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET    = 1'd0,
    CFG_INIT_STOP = 1'd1
  } cfg_idx_t;

  // request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_TICK      = 3'd0,
    REQ_START     = 3'd1,
    REQ_PAUSE     = 3'd2,
    REQ_RESUME    = 3'd3,
    REQ_STOP      = 3'd4,
    REQ_STOP_SKIP = 3'd5
  } req_t;

  // one input word
  typedef struct packed {
    logic [REQ_W-1:0]         req_type;
    logic [FLD_W-1:0]         source_time;
    logic signed [FLD_W-1:0]  stop_amount;
    logic [SKIP_W-1:0]        skip_amount;
  } item_t;

  // one result word
  typedef struct packed {
    logic [FLD_W-1:0]         elapsed;
    logic [FLD_W-1:0]         step_difference;
    logic signed [FLD_W-1:0]  remaining;
    logic signed [FLD_W-1:0]  stopped_value;
    logic                     paused;
    logic                     running;
  } result_t;

  // configuration write
  typedef struct packed {
    logic                     we;
    logic [CFG_IDX_W-1:0]     idx;
    logic [CFG_DATA_W-1:0]    wdata;
  } cfg_wr_t;

endpackage

### src/pst_in_stage.sv
// ----------------------------------------------------------------------------
// pst_in_stage
// input register of the timer; holds one word until the result stage takes it
// ----------------------------------------------------------------------------
module pst_in_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  pst_pkg::item_t in_item,
  input  logic           out_free,
  output logic           fire,
  output pst_pkg::item_t item_r
);
  import pst_pkg::*;

  logic  vld_r;
  logic  vld_nxt;
  logic  accept;

  // word moves on when the result register can take it
  assign fire     = vld_r && out_free;
  assign in_stall = vld_r && !out_free;
  assign accept   = in_valid && !in_stall;

  // valid flag
  always_comb begin
    vld_nxt = vld_r;
    if (accept) begin
      vld_nxt = 1'b1;
    end else if (fire) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
  end

endmodule

### src/pst_core.sv
// ----------------------------------------------------------------------------
// pst_core
// timer state and the single-pass update for one request
// ----------------------------------------------------------------------------
module pst_core #(
  parameter int TIME_WIDTH = pst_pkg::TIME_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  pst_pkg::cfg_wr_t cfg,
  input  logic             fire,
  input  pst_pkg::item_t   item,
  output pst_pkg::result_t res
);
  import pst_pkg::*;

  localparam int XW = (TIME_WIDTH > FLD_W) ? TIME_WIDTH : FLD_W;

  // configuration register
  logic [FLD_W-1:0]        target_time_r;

  // timer state
  logic [TIME_WIDTH-1:0]   base_r,    base_nxt;
  logic [TIME_WIDTH-1:0]   elapsed_r, elapsed_nxt;
  logic signed [FLD_W-1:0] sd_r,      sd_nxt;
  logic [SKIP_W-1:0]       skip_r,    skip_nxt;
  logic                    pause_r,   pause_nxt;
  logic                    run_r,     run_nxt;

  // scratch for the update
  logic [XW-1:0]           now_x;
  logic [TIME_WIDTH-1:0]   now;
  logic [TIME_WIDTH-1:0]   diff;
  logic [XW-1:0]           diff_x;
  logic signed [XW-1:0]    sd_x;
  logic [XW-1:0]           el_x;
  logic [FLD_W-1:0]        el32;
  logic                    do_update;
  logic                    sd_load;

  // source time resized to the internal width
  assign now_x = XW'(item.source_time);
  assign now   = now_x[TIME_WIDTH-1:0];

  // initial delay write loads the stop delay while not running
  assign sd_load = cfg.we && (cfg_idx_t'(cfg.idx) == CFG_INIT_STOP) && !run_r;

  // next state of one request
  always_comb begin
    base_nxt    = base_r;
    elapsed_nxt = elapsed_r;
    sd_nxt      = sd_r;
    skip_nxt    = skip_r;
    pause_nxt   = pause_r;
    run_nxt     = run_r;
    diff        = '0;
    diff_x      = '0;
    sd_x        = '0;
    do_update   = 1'b0;

    case (req_t'(item.req_type))
      REQ_TICK, REQ_RESUME, REQ_STOP, REQ_STOP_SKIP: do_update = 1'b1;
      default:                                       do_update = 1'b0;
    endcase

    if (do_update) begin
      if (!run_r) begin
        // first update starts the timer without advance
        elapsed_nxt = '0;
        run_nxt     = 1'b1;
        base_nxt    = now;
      end else begin
        // backward jump counts as zero
        diff     = (now < base_r) ? '0 : (now - base_r);
        base_nxt = now;
        if (skip_r != '0) begin
          diff     = '0;
          skip_nxt = skip_r - SKIP_W'(1);
        end
        diff_x = XW'(diff);
        if (!pause_r) begin
          if (sd_r > 32'sd0) begin
            // positive delay soaks up the advance, saturating at zero
            if (diff_x >= XW'(unsigned'(sd_r))) begin
              sd_nxt = '0;
            end else begin
              sd_nxt = sd_r - signed'(diff_x[FLD_W-1:0]);
            end
          end else if (sd_r < 32'sd0) begin
            // negative delay added once as a lump
            sd_x        = XW'(sd_r);
            elapsed_nxt = elapsed_r - sd_x[TIME_WIDTH-1:0];
            sd_nxt      = '0;
          end else begin
            elapsed_nxt = elapsed_r + diff;
          end
        end
      end
    end

    // request specific part
    case (req_t'(item.req_type))
      REQ_START: begin
        elapsed_nxt = '0;
        run_nxt     = 1'b1;
        base_nxt    = now;
      end
      REQ_PAUSE: begin
        pause_nxt = 1'b1;
      end
      REQ_RESUME: begin
        pause_nxt = 1'b0;
      end
      REQ_STOP: begin
        sd_nxt = item.stop_amount;
      end
      REQ_STOP_SKIP: begin
        sd_nxt   = item.stop_amount;
        skip_nxt = item.skip_amount;
      end
      default: begin
      end
    endcase
  end

  // result word from the updated state
  assign el_x = XW'(elapsed_nxt);
  assign el32 = el_x[FLD_W-1:0];

  always_comb begin
    res.elapsed         = el32;
    res.step_difference = diff_x[FLD_W-1:0];
    res.remaining       = signed'(target_time_r - el32);
    res.stopped_value   = pause_nxt ? 32'sd1 : sd_nxt;
    res.paused          = pause_nxt;
    res.running         = run_nxt;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r        <= '0;
      elapsed_r     <= '0;
      sd_r          <= '0;
      skip_r        <= '0;
      pause_r       <= 1'b0;
      run_r         <= 1'b0;
      target_time_r <= '0;
    end else begin
      if (fire) begin
        base_r    <= base_nxt;
        elapsed_r <= elapsed_nxt;
        skip_r    <= skip_nxt;
        pause_r   <= pause_nxt;
        run_r     <= run_nxt;
      end
      // stop delay: config load or request update
      if (sd_load) begin
        sd_r <= signed'(cfg.wdata);
      end else if (fire) begin
        sd_r <= sd_nxt;
      end
      // configuration writes must arrive only while idle; the block does not enforce this
      if (cfg.we) begin
        case (cfg_idx_t'(cfg.idx))
          CFG_TARGET: begin
            target_time_r <= cfg.wdata;
          end
          CFG_INIT_STOP: begin
            // only loads the stop delay, see above
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

### src/pst_out_stage.sv
// ----------------------------------------------------------------------------
// pst_out_stage
// result register of the timer, held while the receiver stalls
// ----------------------------------------------------------------------------
module pst_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  pst_pkg::result_t res,
  output logic             out_free,
  output logic             out_valid,
  input  logic             out_stall,
  output pst_pkg::result_t res_r
);
  import pst_pkg::*;

  logic vld_r;
  logic vld_nxt;

  // register can load when empty or when its word leaves this cycle
  assign out_free  = !vld_r || !out_stall;
  assign out_valid = vld_r;

  always_comb begin
    vld_nxt = vld_r;
    if (fire) begin
      vld_nxt = 1'b1;
    end else if (!out_stall) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res;
    end
  end

endmodule

### src/pausable_skip_stop_timer_unit.sv
// ----------------------------------------------------------------------------
// pausable_skip_stop_timer_unit
// elapsed-time counter driven by a source time, with pause, skip and stop
// ----------------------------------------------------------------------------
// Each input word carries a request (tick, start, pause, resume, stop,
// stop-and-skip) with the present source time, and gives exactly one result
// word: elapsed, step difference, remaining, stopped value, paused, running.
// Both channels use valid/stall; a word moves at a clock edge with valid high
// and stall low. The config port (cfg_we, cfg_idx, cfg_wdata) writes the
// target time (index 0) and the initial stop delay (index 1); write only
// while idle.
// Between the input ports and the result ports lie an input register, then
// the update logic feeding the result register. One word per cycle is
// sustained while the receiver does not stall, since the whole update is a
// compare, a subtract and an add on the state in one pass.
// When the receiver stalls, the result register holds its word and the input
// register can still take one more word before in_stall rises.
// Synchronous active-low reset empties both registers, clears the timer
// state and the config; the timer is not running after reset.
// ----------------------------------------------------------------------------
module pausable_skip_stop_timer_unit #(
  parameter int TIME_WIDTH = pst_pkg::TIME_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [pst_pkg::REQ_W-1:0]      in_req_type,
  input  logic [pst_pkg::FLD_W-1:0]      in_source_time,
  input  logic signed [pst_pkg::FLD_W-1:0] in_stop_amount,
  input  logic [pst_pkg::SKIP_W-1:0]     in_skip_amount,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [pst_pkg::FLD_W-1:0]      out_elapsed,
  output logic [pst_pkg::FLD_W-1:0]      out_step_difference,
  output logic signed [pst_pkg::FLD_W-1:0] out_remaining,
  output logic signed [pst_pkg::FLD_W-1:0] out_stopped_value,
  output logic                           out_paused,
  output logic                           out_running,
  // configuration
  input  logic                           cfg_we,
  input  logic [pst_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [pst_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import pst_pkg::*;

  item_t   in_item;
  item_t   item_r;
  result_t res;
  result_t res_r;
  cfg_wr_t cfg;
  logic    fire;
  logic    out_free;

  assign in_item.req_type    = in_req_type;
  assign in_item.source_time = in_source_time;
  assign in_item.stop_amount = in_stop_amount;
  assign in_item.skip_amount = in_skip_amount;

  assign cfg.we    = cfg_we;
  assign cfg.idx   = cfg_idx;
  assign cfg.wdata = cfg_wdata;

  // input register
  pst_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_free (out_free),
    .fire     (fire),
    .item_r   (item_r)
  );

  // state and update
  pst_core #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .fire  (fire),
    .item  (item_r),
    .res   (res)
  );

  // result register
  pst_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .res       (res),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res_r     (res_r)
  );

  assign out_elapsed         = res_r.elapsed;
  assign out_step_difference = res_r.step_difference;
  assign out_remaining       = res_r.remaining;
  assign out_stopped_value   = res_r.stopped_value;
  assign out_paused          = res_r.paused;
  assign out_running         = res_r.running;

`ifndef SYNTH
  // input side only backs up behind a stalled, full result register
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("in_stall without a stalled result");

  // a paused result always reports one as stopped value
  a_pause_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_paused) |-> (out_stopped_value == 32'sd1))
    else $error("paused result with wrong stopped value");

  // a timer that is not running has no elapsed time and no advance
  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_running) |-> (out_elapsed == '0 && out_step_difference == '0))
    else $error("not running but time accumulated");
`endif

endmodule

### sim/pst_timer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pst_timer_checker
// watches both channels and the config port, predicts and compares results
// ----------------------------------------------------------------------------
// Keeps its own copy of the timer state and of the target time register,
// computes the expected result word for every accepted input word and
// compares every accepted result word against the oldest expected one.
// Reports the number of failures and the number of words still due.
// ----------------------------------------------------------------------------
module pst_timer_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  // input channel
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  logic [pst_pkg::REQ_W-1:0]        in_req_type,
  input  logic [pst_pkg::FLD_W-1:0]        in_source_time,
  input  logic signed [pst_pkg::FLD_W-1:0] in_stop_amount,
  input  logic [pst_pkg::SKIP_W-1:0]       in_skip_amount,
  // result channel
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  logic [pst_pkg::FLD_W-1:0]        out_elapsed,
  input  logic [pst_pkg::FLD_W-1:0]        out_step_difference,
  input  logic signed [pst_pkg::FLD_W-1:0] out_remaining,
  input  logic signed [pst_pkg::FLD_W-1:0] out_stopped_value,
  input  logic                             out_paused,
  input  logic                             out_running,
  // configuration
  input  logic                             cfg_we,
  input  logic [pst_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [pst_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  // status towards the test top
  output int                               fail_count,
  output int                               words_due
);

  import pst_pkg::*;

  // shadow target time
  logic [31:0]        target_time_q;

  // shadow timer state
  logic [31:0]        base_q;
  logic [31:0]        elapsed_q;
  logic signed [31:0] stop_q;
  logic [15:0]        skip_q;
  logic               paused_q;
  logic               running_q;

  result_t timer_words_due[$];
  int      failures;
  int      word_no;

  assign fail_count = failures;

  // start or restart: clear elapsed and rebase
  task automatic timer_begin(input logic [31:0] now);
    elapsed_q = '0;
    running_q = 1'b1;
    base_q    = now;
  endtask

  // one timer update, returns the source advance it measured
  task automatic timer_advance(input logic [31:0] now, output logic [31:0] diff);
    if (!running_q) begin
      timer_begin(now);
      diff = '0;
    end else begin
      // a backward jump rebases and counts as zero
      diff   = (now < base_q) ? 32'd0 : now - base_q;
      base_q = now;
      if (skip_q != 16'd0) begin
        diff   = '0;
        skip_q = skip_q - 16'd1;
      end
      if (!paused_q) begin
        if (stop_q > 0) begin
          // positive delay absorbs the advance, saturating at zero
          if (diff >= $unsigned(stop_q))
            stop_q = '0;
          else
            stop_q = stop_q - $signed(diff);
        end else if (stop_q < 0) begin
          // negative delay is added as one lump
          elapsed_q = elapsed_q - $unsigned(stop_q);
          stop_q    = '0;
        end else begin
          elapsed_q = elapsed_q + diff;
        end
      end
    end
  endtask

  // apply one request and build the result word it gives
  task automatic predict_timer_word(input logic [2:0] req, input logic [31:0] now,
                                    input logic [31:0] amount, input logic [15:0] skip,
                                    output result_t word);
    logic [31:0] diff;
    diff = '0;
    case (req)
      REQ_TICK:   timer_advance(now, diff);
      REQ_START:  timer_begin(now);
      REQ_PAUSE:  paused_q = 1'b1;
      REQ_RESUME: begin
        timer_advance(now, diff);
        paused_q = 1'b0;
      end
      REQ_STOP: begin
        timer_advance(now, diff);
        stop_q = amount;
      end
      REQ_STOP_SKIP: begin
        timer_advance(now, diff);
        stop_q = amount;
        skip_q = skip;
      end
      default: ;
    endcase
    word.elapsed         = elapsed_q;
    word.step_difference = diff;
    word.remaining       = target_time_q - elapsed_q;
    word.stopped_value   = paused_q ? 32'sd1 : stop_q;
    word.paused          = paused_q;
    word.running         = running_q;
  endtask

  task automatic report_failure(input string what, input result_t want, input result_t got);
    failures = failures + 1;
    if (failures <= 10) begin
      $display("[%0t] word %0d %s", $realtime, word_no, what);
      $display("  expected el=%h diff=%h rem=%h stop=%h p=%b r=%b",
               want.elapsed, want.step_difference, want.remaining,
               want.stopped_value, want.paused, want.running);
      $display("  actual   el=%h diff=%h rem=%h stop=%h p=%b r=%b",
               got.elapsed, got.step_difference, got.remaining,
               got.stopped_value, got.paused, got.running);
    end
  endtask

  initial begin
    failures = 0;
    word_no  = 0;
  end

  // sample both channels and the config port on every rising edge
  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (!rst_n) begin
      target_time_q = '0;
      base_q        = '0;
      elapsed_q     = '0;
      stop_q        = '0;
      skip_q        = '0;
      paused_q      = 1'b0;
      running_q     = 1'b0;
      timer_words_due.delete();
    end else begin
      // config write, the initial delay also loads the delay while not running
      if (cfg_we) begin
        case (cfg_idx)
          CFG_TARGET: target_time_q = cfg_wdata;
          CFG_INIT_STOP: begin
            if (!running_q)
              stop_q = cfg_wdata;
          end
          default: ;
        endcase
      end

      // result side: compare with the oldest expected word
      if (out_valid && !out_stall) begin
        got.elapsed         = out_elapsed;
        got.step_difference = out_step_difference;
        got.remaining       = out_remaining;
        got.stopped_value   = out_stopped_value;
        got.paused          = out_paused;
        got.running         = out_running;
        if (timer_words_due.size() == 0) begin
          want = '0;
          report_failure("arrived with nothing expected", want, got);
        end else begin
          want = timer_words_due.pop_front();
          if (got.elapsed !== want.elapsed ||
              got.step_difference !== want.step_difference ||
              got.remaining !== want.remaining ||
              got.stopped_value !== want.stopped_value ||
              got.paused !== want.paused ||
              got.running !== want.running)
            report_failure("result mismatch", want, got);
        end
        word_no = word_no + 1;
      end

      // input side: predict the word this request gives
      if (in_valid && !in_stall) begin
        predict_timer_word(in_req_type, in_source_time, in_stop_amount,
                           in_skip_amount, want);
        timer_words_due.push_back(want);
      end
    end
    words_due <= timer_words_due.size();
  end

endmodule

### sim/pausable_skip_stop_timer_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pausable_skip_stop_timer_unit_test
// test top of the pausable skip/stop timer
// ----------------------------------------------------------------------------
// Drives a directed run over the special cases of the timer, then several
// random phases with different config settings, each made mostly of small
// forward steps of the source time with occasional jumps. Both sides idle
// at random. A separate checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module pausable_skip_stop_timer_unit_test;

  import pst_pkg::*;

  localparam int          CYCLE_LIMIT    = 200000;
  localparam int          PHASES         = 5;
  localparam int          WORDS_PER_PHASE = 110;
  // request codes the block leaves unused
  localparam logic [2:0]  REQ_SPARE_A    = 3'd6;
  localparam logic [2:0]  REQ_SPARE_B    = 3'd7;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [2:0]         in_req_type = '0;
  logic [31:0]        in_source_time = '0;
  logic signed [31:0] in_stop_amount = '0;
  logic [15:0]        in_skip_amount = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [31:0]        out_elapsed;
  logic [31:0]        out_step_difference;
  logic signed [31:0] out_remaining;
  logic signed [31:0] out_stopped_value;
  logic               out_paused;
  logic               out_running;
  logic               cfg_we = 1'b0;
  logic [0:0]         cfg_idx = '0;
  logic [31:0]        cfg_wdata = '0;

  int          fail_count;
  int          words_due;
  int          cycle_count = 0;
  int          stall_left = 0;
  logic        no_idle = 1'b0;
  logic [31:0] src_now = '0;

  pausable_skip_stop_timer_unit u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_req_type         (in_req_type),
    .in_source_time      (in_source_time),
    .in_stop_amount      (in_stop_amount),
    .in_skip_amount      (in_skip_amount),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_elapsed         (out_elapsed),
    .out_step_difference (out_step_difference),
    .out_remaining       (out_remaining),
    .out_stopped_value   (out_stopped_value),
    .out_paused          (out_paused),
    .out_running         (out_running),
    .cfg_we              (cfg_we),
    .cfg_idx             (cfg_idx),
    .cfg_wdata           (cfg_wdata)
  );

  pst_timer_checker u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_req_type         (in_req_type),
    .in_source_time      (in_source_time),
    .in_stop_amount      (in_stop_amount),
    .in_skip_amount      (in_skip_amount),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_elapsed         (out_elapsed),
    .out_step_difference (out_step_difference),
    .out_remaining       (out_remaining),
    .out_stopped_value   (out_stopped_value),
    .out_paused          (out_paused),
    .out_running         (out_running),
    .cfg_we              (cfg_we),
    .cfg_idx             (cfg_idx),
    .cfg_wdata           (cfg_wdata),
    .fail_count          (fail_count),
    .words_due           (words_due)
  );

  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // receiver: after each accepted result word hold stall for a randomly drawn span, none when no_idle is set
  always @(posedge clk) begin
    int stall_draw;
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && !out_stall) begin
      stall_draw = no_idle ? 0 : $urandom_range(0, 7);
      stall_left <= stall_draw;
      out_stall  <= (stall_draw != 0);
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else begin
      stall_left <= 0;
      out_stall  <= 1'b0;
    end
  end

  // one word on the input channel, after a random gap
  task automatic send_word(input logic [2:0] req, input logic [31:0] now,
                           input logic [31:0] amount, input logic [15:0] skip);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_req_type    <= req;
    in_source_time <= now;
    in_stop_amount <= amount;
    in_skip_amount <= skip;
    do @(posedge clk); while (in_stall);
  endtask

  // hold off the sender until every expected word has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (words_due != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  // mostly small forward source steps, some jumps, some noise
  task automatic send_random_word();
    int          pick;
    int          mode;
    logic [2:0]  req;
    logic [31:0] amount;
    logic [15:0] skip;
    pick = $urandom_range(0, 99);
    if (pick < 50)      req = REQ_TICK;
    else if (pick < 56) req = REQ_START;
    else if (pick < 64) req = REQ_PAUSE;
    else if (pick < 72) req = REQ_RESUME;
    else if (pick < 84) req = REQ_STOP;
    else if (pick < 96) req = REQ_STOP_SKIP;
    else if (pick < 98) req = REQ_SPARE_A;
    else                req = REQ_SPARE_B;

    mode = $urandom_range(0, 99);
    if (mode < 70)      src_now = src_now + $urandom_range(0, 40);
    else if (mode < 80) src_now = src_now + $urandom_range(0, 3000);
    else if (mode < 88) src_now = src_now - $urandom_range(1, 200);
    else if (mode < 94) src_now = $urandom;
    else                src_now = src_now + $urandom;

    mode = $urandom_range(0, 99);
    if (mode < 60)      amount = $urandom_range(0, 260) - 60;
    else if (mode < 80) amount = $urandom_range(0, 50);
    else if (mode < 90) amount = $urandom;
    else begin
      case ($urandom_range(0, 3))
        0:       amount = 32'h8000_0000;
        1:       amount = 32'h7fff_ffff;
        2:       amount = 32'hffff_ffff;
        default: amount = 32'h0000_0000;
      endcase
    end

    skip = ($urandom_range(0, 99) < 90) ? 16'($urandom_range(0, 4))
                                         : 16'($urandom_range(0, 65535));
    send_word(req, src_now, amount, skip);
  endtask

  initial begin
    int phase;
    int k;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // initial delay loads the stop delay while the timer is not running
    write_reg(CFG_TARGET, 32'd5000);
    write_reg(CFG_INIT_STOP, 32'd40);
    cfg_we <= 1'b0;

    // directed part
    send_word(REQ_TICK, 32'd100, 32'd0, 16'd0);          // tick starts the timer
    send_word(REQ_TICK, 32'd130, 32'd0, 16'd0);          // delay absorbs advance
    send_word(REQ_TICK, 32'd200, 32'd0, 16'd0);          // delay saturates
    send_word(REQ_TICK, 32'd260, 32'd0, 16'd0);
    send_word(REQ_STOP, 32'd300, -32'sd25, 16'd0);
    send_word(REQ_TICK, 32'd310, 32'd0, 16'd0);          // lump added
    send_word(REQ_STOP, 32'd320, 32'h8000_0000, 16'd0);
    send_word(REQ_TICK, 32'd330, 32'd0, 16'd0);          // most negative lump
    send_word(REQ_PAUSE, 32'd340, 32'd0, 16'd0);
    send_word(REQ_TICK, 32'd400, 32'd0, 16'd0);          // difference while paused
    send_word(REQ_RESUME, 32'd450, 32'd0, 16'd0);
    send_word(REQ_TICK, 32'd460, 32'd0, 16'd0);
    send_word(REQ_STOP_SKIP, 32'd470, 32'd0, 16'd2);
    send_word(REQ_TICK, 32'd500, 32'd0, 16'd0);          // skipped
    send_word(REQ_TICK, 32'd600, 32'd0, 16'd0);          // skipped
    send_word(REQ_TICK, 32'd610, 32'd0, 16'd0);
    send_word(REQ_TICK, 32'd5, 32'd0, 16'd0);            // backward jump
    send_word(REQ_START, 32'hffff_fff0, 32'd0, 16'd0);   // restart
    send_word(REQ_TICK, 32'hffff_ffff, 32'd0, 16'd0);
    send_word(REQ_STOP, 32'd0, 32'h7fff_ffff, 16'd0);
    send_word(REQ_TICK, 32'hffff_ffff, 32'd0, 16'd0);    // huge advance saturates
    send_word(REQ_SPARE_A, 32'hffff_ffff, 32'hffff_ffff, 16'hffff);
    send_word(REQ_SPARE_B, 32'd0, 32'd0, 16'd0);
    send_word(REQ_STOP_SKIP, 32'h0000_1000, 32'hffff_ffff, 16'hffff);
    send_word(REQ_STOP_SKIP, 32'h0000_1010, 32'd0, 16'd0);
    src_now = 32'h0000_1010;

    // random phases, each under its own config setting
    for (phase = 0; phase < PHASES; phase++) begin
      drain_results();
      case (phase)
        0: begin
          write_reg(CFG_TARGET, 32'd0);
          write_reg(CFG_INIT_STOP, 32'h8000_0000);
        end
        1: begin
          write_reg(CFG_TARGET, 32'hffff_ffff);
          write_reg(CFG_INIT_STOP, 32'h7fff_ffff);
        end
        2: begin
          write_reg(CFG_TARGET, $urandom);
          write_reg(CFG_INIT_STOP, $urandom);
        end
        3: begin
          write_reg(CFG_TARGET, 32'd1000);
          write_reg(CFG_INIT_STOP, 32'd0);
        end
        default: begin
          write_reg(CFG_TARGET, $urandom);
          write_reg(CFG_INIT_STOP, 32'hffff_ffff);
        end
      endcase
      cfg_we  <= 1'b0;
      no_idle <= (phase == 2);
      for (k = 0; k < WORDS_PER_PHASE; k++) begin
        // sender waits for everything outstanding once mid-phase
        if (phase == 1 && k == WORDS_PER_PHASE / 2)
          drain_results();
        send_random_word();
      end
    end

    drain_results();
    if (fail_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

### files.f
src/pst_pkg.sv
src/pst_in_stage.sv
src/pst_core.sv
src/pst_out_stage.sv
src/pausable_skip_stop_timer_unit.sv
sim/pst_timer_checker.sv
sim/pausable_skip_stop_timer_unit_test.sv
